// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising edge, skipped while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same check, also evaluated while reset is high
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/utd_pkg.sv -----
`timescale 1ns / 1ps

package utd_pkg;

  localparam int BYTE_W          = 8;
  localparam int CP_W            = 21;
  localparam int STATUS_W        = 2;
  localparam int LINE_OUT_W      = 32;
  localparam int LINE_COUNT_BITS = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;

  localparam logic [CP_W-1:0] CP_LF       = CP_W'(8'h0A);
  localparam logic [CP_W-1:0] CP_CR       = CP_W'(8'h0D);
  localparam logic [CP_W-1:0] CP_QUESTION = CP_W'(8'h3F);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_STRAY    = 2'd1,
    ST_BAD_CONT = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  // one queue entry: an optional code point result, optionally followed by the end result
  typedef struct packed {
    logic [CP_W-1:0] cp;
    status_t         status;
    logic            has_cp;
    logic            eos;
  } utd_evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } utd_fifo_stat_t;

endpackage

// ----- hw/rtl/utd_front.sv -----
`timescale 1ns / 1ps

module utd_front
  import utd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
  input  logic                  s_tlast,   // end_of_input
  input  utd_fifo_stat_t        fifo_stat,
  output logic                  push,
  output utd_evt_t              push_evt
);

  logic [1:0]        bytes_pending, bytes_pending_next;
  logic [BYTE_W-1:0] lead_byte, lead_byte_next;
  logic [CP_W-1:0]   partial_value, partial_value_next;
  logic [CP_W-1:0]   shifted;
  logic [BYTE_W-1:0] b;
  logic              accept;
  logic              emit;

  assign s_tready = !fifo_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata[BYTE_W-1:0];
  assign shifted  = {partial_value[CP_W-7:0], b[5:0]};
  assign push     = accept && emit;

  always_comb begin
    bytes_pending_next = bytes_pending;
    lead_byte_next     = lead_byte;
    partial_value_next = partial_value;
    emit               = 1'b0;
    push_evt           = '{cp: '0, status: ST_OK, has_cp: 1'b0, eos: 1'b0};

    if (s_tlast) begin
      emit               = 1'b1;
      push_evt.eos       = 1'b1;
      if (bytes_pending != 2'd0) begin
        push_evt.cp     = CP_W'(lead_byte);
        push_evt.status = ST_TRUNC;
        push_evt.has_cp = 1'b1;
      end
      bytes_pending_next = 2'd0;
      lead_byte_next     = '0;
      partial_value_next = '0;
    end else if (bytes_pending != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        emit               = 1'b1;
        push_evt.cp        = CP_W'(lead_byte);
        push_evt.status    = ST_BAD_CONT;
        push_evt.has_cp    = 1'b1;
        bytes_pending_next = 2'd0;
        lead_byte_next     = '0;
        partial_value_next = '0;
      end else if (bytes_pending == 2'd1) begin
        emit               = 1'b1;
        push_evt.cp        = shifted;
        push_evt.has_cp    = 1'b1;
        bytes_pending_next = 2'd0;
        lead_byte_next     = '0;
        partial_value_next = '0;
      end else begin
        bytes_pending_next = bytes_pending - 2'd1;
        partial_value_next = shifted;
      end
    end else begin
      if (b inside {[8'h00:8'h7F]}) begin
        emit            = 1'b1;
        push_evt.cp     = CP_W'(b);
        push_evt.has_cp = 1'b1;
      end else if (b inside {[8'hC0:8'hDF]}) begin
        bytes_pending_next = 2'd1;
        lead_byte_next     = b;
        partial_value_next = CP_W'(b[4:0]);
      end else if (b inside {[8'hE0:8'hEF]}) begin
        bytes_pending_next = 2'd2;
        lead_byte_next     = b;
        partial_value_next = CP_W'(b[3:0]);
      end else if (b inside {[8'hF0:8'hFF]}) begin
        bytes_pending_next = 2'd3;
        lead_byte_next     = b;
        partial_value_next = CP_W'(b[2:0]);
      end else begin
        // stray continuation byte
        emit            = 1'b1;
        push_evt.cp     = CP_QUESTION;
        push_evt.status = ST_STRAY;
        push_evt.has_cp = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= 2'd0;
      lead_byte     <= '0;
      partial_value <= '0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      lead_byte     <= lead_byte_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

// ----- hw/rtl/utd_fifo.sv -----
`timescale 1ns / 1ps

module utd_fifo
  import utd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  utd_evt_t       push_evt,
  input  logic           pop,
  output utd_evt_t       head,
  output utd_fifo_stat_t stat
);

  utd_evt_t           entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/utd_back.sv -----
`timescale 1ns / 1ps

module utd_back
  import utd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  utd_fifo_stat_t         fifo_stat,
  input  utd_evt_t               head,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // [20:0] code_point, [52:21] line_count, [55:53] zero
  output logic [STATUS_W-1:0]    m_tuser,  // [1:0] status
  output logic                   m_tlast   // end_of_stream
);

  logic [LINE_COUNT_BITS-1:0] line_counter, line_counter_next;
  logic                       pend_eos;
  logic [CP_W-1:0]            out_cp;
  status_t                    out_status;
  logic [LINE_OUT_W-1:0]      out_lc;
  logic                       load;
  logic                       is_newline;

  assign load       = !m_tvalid || m_tready;
  assign pop        = load && !pend_eos && !fifo_stat.empty;
  assign is_newline = (head.cp == CP_LF) || (head.cp == CP_CR);

  always_comb begin
    line_counter_next = line_counter;
    if (pop && head.has_cp && is_newline && (line_counter != '1)) begin
      line_counter_next = line_counter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      m_tlast      <= 1'b0;
      pend_eos     <= 1'b0;
      line_counter <= '0;
      out_cp       <= '0;
      out_status   <= ST_OK;
      out_lc       <= '0;
    end else if (load) begin
      line_counter <= line_counter_next;
      out_lc       <= LINE_OUT_W'(line_counter_next);
      if (pend_eos) begin
        // end result after a truncated sequence
        m_tvalid   <= 1'b1;
        m_tlast    <= 1'b1;
        out_cp     <= '0;
        out_status <= ST_OK;
        pend_eos   <= 1'b0;
      end else if (pop) begin
        m_tvalid <= 1'b1;
        if (head.has_cp) begin
          m_tlast    <= 1'b0;
          out_cp     <= head.cp;
          out_status <= head.status;
          pend_eos   <= head.eos;
        end else begin
          m_tlast    <= 1'b1;
          out_cp     <= '0;
          out_status <= ST_OK;
        end
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {(OUT_TDATA_W-CP_W-LINE_OUT_W)'(0), out_lc, out_cp};
  assign m_tuser = out_status;

endmodule

// ----- hw/rtl/utf8_to_codepoint_decoder_core.sv -----
`timescale 1ns / 1ps

// utf-8 byte stream to code point decoder
// input stream: s_tdata[7:0] carries one raw byte per transaction; s_tlast set
// marks end of input (byte ignored) and yields a final result with m_tlast set.
// output stream: m_tdata[20:0] code point, m_tdata[52:21] running cr/lf count,
// m_tuser[1:0] status (ok, stray byte, bad continuation, truncated at end).
// a result passes from front decode into the event queue, then into the
// output register. throughput: one byte per cycle while the queue has room;
// a byte that only extends a sequence gives no result. an end marker that cuts
// a sequence gives two results, and the second holds back the queue; the
// four-entry event queue absorbs this.
// when the receiver stalls, the output register holds, the queue fills and
// s_tready drops once the queue is full; nothing is lost.
// reset (rst, synchronous, active high) clears the sequence state, the queue,
// the output register and the line counter; the block is ready the next cycle.
module utf8_to_codepoint_decoder_core
  import utd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
  input  logic                   s_tlast,   // end_of_input
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [20:0] code_point, [52:21] line_count, [55:53] zero
  output logic [STATUS_W-1:0]    m_tuser,   // [1:0] status
  output logic                   m_tlast    // end_of_stream
);

  utd_fifo_stat_t fifo_stat;
  utd_evt_t       push_evt;
  utd_evt_t       head;
  logic           push;
  logic           pop;

  utd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_evt  (push_evt)
  );

  utd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_evt (push_evt),
    .pop      (pop),
    .head     (head),
    .stat     (fifo_stat)
  );

  utd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_stat (fifo_stat),
    .head      (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ----- hw/rtl/utd_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utd_checker
  import utd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic                   s_tlast,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [STATUS_W-1:0]    m_tuser,
  input logic                   m_tlast
);

  logic unused_in;
  assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata) ^ s_tlast;

  `CHK_ASSERT(a_valid_held, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "output transaction withdrawn")
  `CHK_ASSERT(a_data_held, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output changed")
  `CHK_ASSERT(a_eos_clean, clk, rst, m_tvalid && m_tlast |-> m_tdata[20:0] == '0 && m_tuser == ST_OK, "end result carries a code point or status")
  `CHK_ASSERT(a_stray_q, clk, rst, m_tvalid && m_tuser == ST_STRAY |-> m_tdata[20:0] == CP_QUESTION && !m_tlast, "stray byte not replaced by question mark")
  `CHK_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid, "output valid right after reset")

endmodule

bind utf8_to_codepoint_decoder_core utd_checker u_utd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- sim/tb_utf8_to_codepoint_decoder_core.sv -----
`timescale 1ns / 1ps

module tb_utf8_to_codepoint_decoder_core;
  import utd_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0]       cp;
    status_t               st;
    logic                  eos;
    logic [LINE_OUT_W-1:0] lc;
  } cp_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              eoi;
    logic              typed;
    cp_result_t        want;
  } dir_row_t;

  localparam cp_result_t NO_RESULT = '{21'h0, ST_OK, 1'b0, 32'd0};
  localparam int         N_DIR     = 27;
  localparam int         N_RANDOM  = 850;

  // typed rows give exactly one result; the others go through the predictor
  localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
    '{8'h00, 1'b0, 1'b1, '{21'h00, ST_OK, 1'b0, 32'd0}},
    '{8'h7F, 1'b0, 1'b1, '{21'h7F, ST_OK, 1'b0, 32'd0}},
    '{8'h0A, 1'b0, 1'b1, '{21'h0A, ST_OK, 1'b0, 32'd1}},
    '{8'h0D, 1'b0, 1'b1, '{21'h0D, ST_OK, 1'b0, 32'd2}},
    '{8'h80, 1'b0, 1'b1, '{21'h3F, ST_STRAY, 1'b0, 32'd2}},
    '{8'hBF, 1'b0, 1'b1, '{21'h3F, ST_STRAY, 1'b0, 32'd2}},
    '{8'hC2, 1'b0, 1'b0, NO_RESULT},
    '{8'hA9, 1'b0, 1'b0, NO_RESULT},
    '{8'hE2, 1'b0, 1'b0, NO_RESULT},
    '{8'h82, 1'b0, 1'b0, NO_RESULT},
    '{8'hAC, 1'b0, 1'b0, NO_RESULT},
    '{8'hF0, 1'b0, 1'b0, NO_RESULT},
    '{8'h9F, 1'b0, 1'b0, NO_RESULT},
    '{8'h98, 1'b0, 1'b0, NO_RESULT},
    '{8'h80, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hBF, 1'b0, 1'b0, NO_RESULT},
    '{8'hBF, 1'b0, 1'b0, NO_RESULT},
    '{8'hBF, 1'b0, 1'b1, '{21'h1FFFFF, ST_OK, 1'b0, 32'd2}},
    '{8'hC3, 1'b0, 1'b0, NO_RESULT},
    '{8'h41, 1'b0, 1'b1, '{21'hC3, ST_BAD_CONT, 1'b0, 32'd2}},
    '{8'hE0, 1'b0, 1'b0, NO_RESULT},
    '{8'h80, 1'b0, 1'b0, NO_RESULT},
    '{8'hFE, 1'b0, 1'b1, '{21'hE0, ST_BAD_CONT, 1'b0, 32'd2}},
    '{8'hF8, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b1, '{21'h00, ST_OK, 1'b1, 32'd2}}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] data_byte
  logic                   s_tlast = 1'b0; // end_of_input
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [20:0] code_point, [52:21] line_count
  logic [STATUS_W-1:0]    m_tuser;        // [1:0] status
  logic                   m_tlast;        // end_of_stream

  // predictor state
  logic [1:0]                 seq_left = '0;
  logic [BYTE_W-1:0]          seq_lead = '0;
  logic [CP_W-1:0]            seq_bits = '0;
  logic [LINE_COUNT_BITS-1:0] breaks_seen = '0;

  cp_result_t step_out[$];
  cp_result_t awaited_points[$];

  int error_count    = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  bit hold_done      = 1'b0;
  bit input_stalled  = 1'b0;

  utf8_to_codepoint_decoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (error_count < 40)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic emit_point(input logic [CP_W-1:0] cp, input status_t st, input logic eos);
    cp_result_t r;
    if (!eos && (cp == CP_LF || cp == CP_CR) && breaks_seen != '1)
      breaks_seen++;
    r.cp  = cp;
    r.st  = st;
    r.eos = eos;
    r.lc  = LINE_OUT_W'(breaks_seen);
    step_out.push_back(r);
  endtask

  task automatic decode_step(input logic [BYTE_W-1:0] b, input logic eoi);
    step_out.delete();
    if (eoi) begin
      if (seq_left != 0)
        emit_point(CP_W'(seq_lead), ST_TRUNC, 1'b0);
      seq_left = '0;
      seq_lead = '0;
      seq_bits = '0;
      emit_point('0, ST_OK, 1'b1);
    end else if (seq_left != 0) begin
      if (b[7:6] != 2'b10) begin
        emit_point(CP_W'(seq_lead), ST_BAD_CONT, 1'b0);
        seq_left = '0;
        seq_lead = '0;
        seq_bits = '0;
      end else begin
        seq_bits = CP_W'({seq_bits, b[5:0]});
        seq_left = seq_left - 2'd1;
        if (seq_left == 0) begin
          emit_point(seq_bits, ST_OK, 1'b0);
          seq_lead = '0;
          seq_bits = '0;
        end
      end
    end else if (!b[7]) begin
      emit_point(CP_W'(b), ST_OK, 1'b0);
    end else if (b[7:5] == 3'b110) begin
      seq_left = 2'd1;
      seq_bits = CP_W'(b[4:0]);
      seq_lead = b;
    end else if (b[7:4] == 4'b1110) begin
      seq_left = 2'd2;
      seq_bits = CP_W'(b[3:0]);
      seq_lead = b;
    end else if (b[7:4] == 4'b1111) begin
      seq_left = 2'd3;
      seq_bits = CP_W'(b[2:0]);
      seq_lead = b;
    end else begin
      emit_point(CP_QUESTION, ST_STRAY, 1'b0);
    end
  endtask

  // random idle gap, with stretches of no idling on either side
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((items_sent % 300) >= 240) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic eoi,
                           input logic typed, input cp_result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eoi;
    do begin
      @(posedge clk);
      if (!s_tready) input_stalled = 1'b1;
    end while (!s_tready);
    decode_step(b, eoi);
    if (typed)
      awaited_points.push_back(want);
    else
      foreach (step_out[i]) awaited_points.push_back(step_out[i]);
    items_sent++;
    @(negedge clk);
  endtask

  // len: sequence length named by the lead byte; keep continuation bytes sent; ending: 0 done, 1 bad byte, 2 end marker
  task automatic send_sequence(input int len, input int keep, input int ending);
    logic [BYTE_W-1:0] lead_b;
    logic [BYTE_W-1:0] junk;
    if (len == 2)      lead_b = {3'b110, 5'($urandom)};
    else if (len == 3) lead_b = {4'b1110, 4'($urandom)};
    else               lead_b = {4'b1111, 4'($urandom)};
    send_item(lead_b, 1'b0, 1'b0, NO_RESULT);
    repeat (keep) send_item({2'b10, 6'($urandom)}, 1'b0, 1'b0, NO_RESULT);
    if (ending == 1) begin
      junk = 8'($urandom);
      if (junk[7:6] == 2'b10) junk[6] = 1'b1;
      send_item(junk, 1'b0, 1'b0, NO_RESULT);
    end else if (ending == 2) begin
      send_item(8'($urandom), 1'b1, 1'b0, NO_RESULT);
    end
  endtask

  always @(posedge clk) begin
    cp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      status_seen[m_tuser]++;
      if (awaited_points.size() == 0) begin
        note_mismatch("result with nothing awaited", 32'(m_tdata[CP_W-1:0]), 32'd0);
      end else begin
        want = awaited_points.pop_front();
        if (m_tdata[CP_W-1:0] != want.cp)
          note_mismatch("code_point", 32'(m_tdata[CP_W-1:0]), 32'(want.cp));
        if (m_tdata[CP_W+LINE_OUT_W-1:CP_W] != want.lc)
          note_mismatch("line_count", m_tdata[CP_W+LINE_OUT_W-1:CP_W], want.lc);
        if (m_tuser != want.st)
          note_mismatch("status", 32'(m_tuser), 32'(want.st));
        if (m_tlast != want.eos)
          note_mismatch("end_of_stream", 32'(m_tlast), 32'(want.eos));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the input side backs up
  initial begin
    int g;
    forever begin
      if (!hold_done && items_sent >= 350) begin
        m_tready <= 1'b0;
        for (int k = 0; k < 200; k++) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          m_tready <= 1'b0;
          repeat (g) @(negedge clk);
        end
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int kind;
    int len;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_item(DIR_ROWS[i].b, DIR_ROWS[i].eoi, DIR_ROWS[i].typed, DIR_ROWS[i].want);

    while (items_sent < N_DIR + N_RANDOM) begin
      kind = $urandom_range(0, 99);
      len  = $urandom_range(2, 4);
      if (kind < 35) begin
        if ($urandom_range(0, 9) == 0)
          send_item($urandom_range(0, 1) ? 8'h0A : 8'h0D, 1'b0, 1'b0, NO_RESULT);
        else
          send_item({1'b0, 7'($urandom)}, 1'b0, 1'b0, NO_RESULT);
      end else if (kind < 80) begin
        send_sequence(len, len - 1, 0);
      end else if (kind < 85) begin
        send_item({2'b10, 6'($urandom)}, 1'b0, 1'b0, NO_RESULT);
      end else if (kind < 90) begin
        send_sequence(len, $urandom_range(0, len - 2), 1);
      end else if (kind < 94) begin
        send_sequence(len, $urandom_range(0, len - 2), 2);
      end else if (kind < 97) begin
        send_item(8'($urandom), 1'b1, 1'b0, NO_RESULT);
      end else begin
        send_item(8'($urandom), 1'b0, 1'b0, NO_RESULT);
      end
    end
    s_tvalid <= 1'b0;

    while (awaited_points.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d bytes and end markers, checked %0d results, %0d line breaks counted",
             items_sent, results_seen, breaks_seen);
    $display("results by status: ok %0d, stray %0d, bad continuation %0d, truncated %0d%s",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             input_stalled ? ", input backpressure seen" : "");
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
